### hw/rtl/hec_pkg.sv
package hec_pkg;

	// widths of the item fields and the length register
	localparam int MAX_DATA_BITS   = 57;
	localparam int MSG_W           = 57;
	localparam int CODE_W          = 63;
	localparam int SYN_W           = 6;
	localparam int CFG_W           = 6;
	localparam int DATA_BITS_RESET = 4;

	// item modes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// stage 1 to stage 2: placed or masked codeword
	typedef struct packed {
		logic              mode;
		logic [CODE_W-1:0] code;
		logic [SYN_W-1:0]  len;
	} hec_s1_t;

	// stage 2 to stage 3: codeword plus syndrome
	typedef struct packed {
		logic              mode;
		logic [CODE_W-1:0] code;
		logic [SYN_W-1:0]  len;
		logic [SYN_W-1:0]  syn;
	} hec_s2_t;

	// bit index in the codeword of message bit k (k-th non-power-of-two position)
	function automatic int msg_bit_pos(input int k);
		int cnt;
		int res;
		cnt = 0;
		res = 0;
		for (int p = 3; p <= CODE_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				if (cnt == k) begin
					res = p - 1;
				end
				cnt++;
			end
		end
		return res;
	endfunction

	// code positions covered by parity bit i
	function automatic logic [CODE_W-1:0] cover_mask(input int i);
		logic [CODE_W-1:0] msk;
		msk = '0;
		for (int b = 0; b < CODE_W; b++) begin
			msk[b] = (((b + 1) >> i) & 1) != 0;
		end
		return msk;
	endfunction

	// code length n = m + r for a clamped message length m
	function automatic logic [SYN_W-1:0] code_len(input logic [CFG_W-1:0] m);
		logic [SYN_W-1:0] r;
		if (m <= CFG_W'(1)) begin
			r = SYN_W'(2);
		end else if (m <= CFG_W'(4)) begin
			r = SYN_W'(3);
		end else if (m <= CFG_W'(11)) begin
			r = SYN_W'(4);
		end else if (m <= CFG_W'(26)) begin
			r = SYN_W'(5);
		end else begin
			r = SYN_W'(6);
		end
		return SYN_W'(m) + r;
	endfunction

endpackage

### hw/rtl/hec_in_if.sv
interface hec_in_if import hec_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             mode;
	logic [MSG_W-1:0] message;
	logic [CODE_W-1:0] received_code;

	modport source (output valid, mode, message, received_code, input ready);
	modport sink (input valid, mode, message, received_code, output ready);
endinterface

### hw/rtl/hec_out_if.sv
interface hec_out_if import hec_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code_out;
	logic [SYN_W-1:0]  error_position;
	logic              position_out_of_range;

	modport source (output valid, code_out, error_position, position_out_of_range,
		input ready);
	modport sink (input valid, code_out, error_position, position_out_of_range,
		output ready);
endinterface

### hw/rtl/hec_cfg_if.sv
interface hec_cfg_if import hec_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CFG_W-1:0] data_bits;

	modport source (output valid, data_bits, input ready);
	modport sink (input valid, data_bits, output ready);
endinterface

### hw/rtl/hamming_encode_and_correct_unit.sv
// Hamming single-error-correcting encoder and checker.
// item_in carries mode, message and received_code; mode 0 encodes the low
// data_bits message bits into a codeword, mode 1 checks received_code and
// corrects one flipped position. result_out carries code_out, the syndrome
// in error_position and position_out_of_range when the syndrome lies beyond
// the code length (no correction then). Bit k of a codeword is position k+1.
// cfg sets data_bits (message length, clamped to 1..57); it is always ready
// and is to be written only while no item is in flight.
// Pipeline: three register stages (placement, syndrome trees, correction with
// the output register). One item per cycle is taken as long as the receiver
// keeps taking results.
// When result_out stalls, the three stages fill one after another and
// item_in drops ready only once all of them hold an item; nothing is lost.
// Reset empties the pipeline and sets data_bits to 4.
module hamming_encode_and_correct_unit import hec_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	hec_in_if.sink    item_in,
	hec_out_if.source result_out,
	hec_cfg_if.sink   cfg
);

	logic [CFG_W-1:0] data_bits_q;
	logic             valid_s1;
	logic             ready_s1;
	hec_s1_t          data_s1;
	logic             valid_s2;
	logic             ready_s2;
	hec_s2_t          data_s2;

	// message length register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= CFG_W'(DATA_BITS_RESET);
		end else if (cfg.valid) begin
			data_bits_q <= cfg.data_bits;
		end
	end

	hec_place u_place (
		.clk           (clk),
		.arst_n        (arst_n),
		.up_valid      (item_in.valid),
		.up_ready      (item_in.ready),
		.mode          (item_in.mode),
		.message       (item_in.message),
		.received_code (item_in.received_code),
		.data_bits     (data_bits_q),
		.dn_valid      (valid_s1),
		.dn_data       (data_s1),
		.dn_ready      (ready_s1)
	);

	hec_syndrome u_syndrome (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_s1),
		.up_ready (ready_s1),
		.up_data  (data_s1),
		.dn_valid (valid_s2),
		.dn_data  (data_s2),
		.dn_ready (ready_s2)
	);

	hec_correct u_correct (
		.clk                   (clk),
		.arst_n                (arst_n),
		.up_valid              (valid_s2),
		.up_ready              (ready_s2),
		.up_data               (data_s2),
		.dn_valid              (result_out.valid),
		.code_out              (result_out.code_out),
		.error_position        (result_out.error_position),
		.position_out_of_range (result_out.position_out_of_range),
		.dn_ready              (result_out.ready)
	);

	// an empty output stage never blocks the input
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_out.valid |-> item_in.ready)
		else $error("input stalled with empty output stage");

	// a full, stalled pipeline refuses new items
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && result_out.valid && !result_out.ready)
		|-> !item_in.ready)
		else $error("input accepted into a full stalled pipeline");

	// out-of-range flag only comes with a nonzero syndrome
	a_oor_has_syndrome: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.position_out_of_range)
		|-> (result_out.error_position != '0))
		else $error("out-of-range flag with zero syndrome");

endmodule

### hw/rtl/hec_place.sv
module hec_place import hec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  logic              mode,
	input  logic [MSG_W-1:0]  message,
	input  logic [CODE_W-1:0] received_code,
	input  logic [CFG_W-1:0]  data_bits,
	output logic              dn_valid,
	output hec_s1_t           dn_data,
	input  logic              dn_ready
);

	logic [CFG_W-1:0]  m_eff;
	logic [SYN_W-1:0]  n;
	logic [CODE_W-1:0] len_mask;
	logic [MSG_W-1:0]  msg_keep;
	logic [CODE_W-1:0] placed;
	hec_s1_t           s1_d;
	logic              valid_s1;
	hec_s1_t           data_s1;

	// clamp message length to the supported range
	always_comb begin
		if (data_bits == '0) begin
			m_eff = CFG_W'(1);
		end else if (data_bits > CFG_W'(MAX_DATA_BITS)) begin
			m_eff = CFG_W'(MAX_DATA_BITS);
		end else begin
			m_eff = data_bits;
		end
	end

	assign n        = code_len(m_eff);
	assign len_mask = ~({CODE_W{1'b1}} << n);
	assign msg_keep = message & ~({MSG_W{1'b1}} << m_eff);

	// scatter message bits into the data positions, parity slots left at zero
	always_comb begin
		placed = '0;
		for (int k = 0; k < MSG_W; k++) begin
			placed[msg_bit_pos(k)] = msg_keep[k];
		end
	end

	always_comb begin
		s1_d.mode = mode;
		s1_d.code = (mode == MODE_DECODE) ? (received_code & len_mask) : placed;
		s1_d.len  = n;
	end

	// stage handshake
	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= s1_d;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

### hw/rtl/hec_syndrome.sv
module hec_syndrome import hec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    up_valid,
	output logic    up_ready,
	input  hec_s1_t up_data,
	output logic    dn_valid,
	output hec_s2_t dn_data,
	input  logic    dn_ready
);

	logic [SYN_W-1:0] syn;
	logic             valid_s2;
	hec_s2_t          data_s2;

	// one xor tree per parity bit over the covered positions
	always_comb begin
		for (int i = 0; i < SYN_W; i++) begin
			syn[i] = ^(up_data.code & cover_mask(i));
		end
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2.mode <= up_data.mode;
			data_s2.code <= up_data.code;
			data_s2.len  <= up_data.len;
			data_s2.syn  <= syn;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule

### hw/rtl/hec_correct.sv
module hec_correct import hec_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  hec_s2_t           up_data,
	output logic              dn_valid,
	output logic [CODE_W-1:0] code_out,
	output logic [SYN_W-1:0]  error_position,
	output logic              position_out_of_range,
	input  logic              dn_ready
);

	logic [CODE_W-1:0] code_d;
	logic [SYN_W-1:0]  err_d;
	logic              oor_d;
	logic              valid_s3;
	logic [CODE_W-1:0] code_s3;
	logic [SYN_W-1:0]  err_s3;
	logic              oor_s3;

	// encode: drop parity into power-of-two slots; decode: flip named position if in range
	always_comb begin
		code_d = up_data.code;
		err_d  = '0;
		oor_d  = 1'b0;
		if (up_data.mode == MODE_ENCODE) begin
			for (int i = 0; i < SYN_W; i++) begin
				code_d[(1 << i) - 1] = up_data.syn[i];
			end
		end else begin
			err_d = up_data.syn;
			if (up_data.syn > up_data.len) begin
				oor_d = 1'b1;
			end else if (up_data.syn != '0) begin
				code_d = up_data.code ^ (CODE_W'(1) << (up_data.syn - SYN_W'(1)));
			end
		end
	end

	// output register
	assign up_ready = !valid_s3 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			code_s3 <= code_d;
			err_s3  <= err_d;
			oor_s3  <= oor_d;
		end
	end

	assign dn_valid              = valid_s3;
	assign code_out              = code_s3;
	assign error_position        = err_s3;
	assign position_out_of_range = oor_s3;

endmodule
